### rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_pkg: shared types and codes for the double-ended queue
// request and status codes, word width and the cell control bundle
// ---------------------------------------------------------------------------
package deq_pkg;

    localparam int WORD_W        = 32;
    localparam int REQ_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LIST       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DROP_FRONT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DROP_BACK  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ENTRY = 2'd3;

    typedef logic signed [WORD_W-1:0] word_t;

    // shift control broadcast to every cell
    typedef struct packed {
        logic shift_right;   // push front: every cell takes its left neighbor
        logic shift_left;    // drop front or listing: take right neighbor
        logic wrap;          // listing: tail cell takes the head word
        logic write_back;    // push back: cell at the fill position loads
    } cell_ctrl_t;

    // per-cell position flags
    typedef struct packed {
        logic at_tail;       // cell holds the back entry
        logic at_fill;       // cell is the first free slot
    } cell_pos_t;

endpackage

### rtl/deq_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_req_if: request channel of the double-ended queue
// valid/ready handshake carrying request type and push word
// ---------------------------------------------------------------------------
interface deq_req_if
    import deq_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic signed [WORD_W-1:0] item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

### rtl/deq_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_rsp_if: result channel of the double-ended queue
// valid/ready handshake carrying status, listed word and last flag
// ---------------------------------------------------------------------------
interface deq_rsp_if
    import deq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] entry_value;
    logic                     last;

    modport source (output valid, output status, output entry_value, output last,
                    input ready);
    modport sink   (input valid, input status, input entry_value, input last,
                    output ready);
endinterface

### rtl/deq_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_cell: one storage cell of the queue chain
// holds one word and takes a neighbor's word on shifts
// ---------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  cell_pos_t  pos,
    input  word_t      left_value,
    input  word_t      right_value,
    input  word_t      head_value,
    input  word_t      push_value,
    output word_t      value
);

    word_t value_reg;
    word_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift_right)
        begin
            value_next = left_value;
        end
        else if (ctrl.shift_left)
        begin
            value_next = (ctrl.wrap && pos.at_tail) ? head_value : right_value;
        end
        else if (ctrl.write_back && pos.at_fill)
        begin
            value_next = push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// push and drop requests give their single result in the cycle after acceptance
// a listing of n entries gives n results, one per cycle while the result side is free,
// the first in the cycle after acceptance; throughput: one request per cycle for push and
// drop while the result side is free; requests are held off until a listing's last entry
// is emitted; the rate is set by the cell chain, rotating one word past the head per cycle
// reset clears the fill count, the listing sequencer and the output valid; stored words and
// the result payload are undefined until written
// ---------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// entries sit in a chain of cells, front entry always in cell 0
// ---------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    deq_req_if.sink       req,
    deq_rsp_if.source     rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    // fill count and listing sequencer
    logic [CW-1:0] count_reg, count_next;
    logic          busy_reg, busy_next;
    logic [CW-1:0] remain_reg, remain_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    word_t               out_value_reg, out_value_next;
    logic                out_last_reg, out_last_next;

    cell_ctrl_t ctrl;
    word_t      cell_value [DEPTH];

    logic out_free;
    logic accept;
    logic is_full;
    logic is_empty;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !busy_reg && out_free;
    assign accept    = req.valid && req.ready;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        count_next      = count_reg;
        busy_next       = busy_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        ctrl            = '0;

        if (busy_reg && out_free)
        begin
            // listing in progress: emit head word and rotate it to the tail
            out_valid_next  = 1'b1;
            out_status_next = ST_ENTRY;
            out_value_next  = cell_value[0];
            out_last_next   = (remain_reg == CW'(1));
            ctrl.shift_left = 1'b1;
            ctrl.wrap       = 1'b1;
            remain_next     = remain_reg - CW'(1);
            busy_next       = (remain_reg != CW'(1));
        end
        else if (accept)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_DONE;
            out_value_next  = '0;
            out_last_next   = 1'b1;
            case (req.req_type)
                REQ_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.shift_right = 1'b1;
                        count_next       = count_reg + CW'(1);
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.write_back = 1'b1;
                        count_next      = count_reg + CW'(1);
                    end
                end
                REQ_LIST:
                begin
                    if (is_empty)
                    begin
                        out_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        // first entry goes out now, the rest follow one a cycle while the result side is free
                        out_status_next = ST_ENTRY;
                        out_value_next  = cell_value[0];
                        out_last_next   = (count_reg == CW'(1));
                        ctrl.shift_left = 1'b1;
                        ctrl.wrap       = 1'b1;
                        remain_next     = count_reg - CW'(1);
                        busy_next       = (count_reg != CW'(1));
                    end
                end
                REQ_DROP_FRONT:
                begin
                    if (is_empty)
                    begin
                        out_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.shift_left = 1'b1;
                        count_next      = count_reg - CW'(1);
                    end
                end
                REQ_DROP_BACK:
                begin
                    if (is_empty)
                    begin
                        out_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    // unused request code: plain done
                    out_status_next = ST_DONE;
                end
            endcase
        end
    end

    // the chain of cells; cell 0 is the front of the queue
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_pos_t pos;
        word_t     left_v;
        word_t     right_v;

        assign pos.at_tail = (count_reg == CW'(i + 1));
        assign pos.at_fill = (count_reg == CW'(i));
        assign left_v      = (i == 0) ? req.item_value : cell_value[(i == 0) ? 0 : i - 1];
        assign right_v     = (i == DEPTH - 1) ? cell_value[i]
                                              : cell_value[(i == DEPTH - 1) ? i : i + 1];

        deq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .pos         (pos),
            .left_value  (left_v),
            .right_value (right_v),
            .head_value  (cell_value[0]),
            .push_value  (req.item_value),
            .value       (cell_value[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_value = out_value_reg;
    assign rsp.last        = out_last_reg;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the double-ended queue
// a shadow copy of the ring predicts every result of each accepted request;
// directed corner requests come first, then random fill and drain sequences
// run with random idle gaps on both channels
// ---------------------------------------------------------------------------
import deq_pkg::*;

typedef struct packed {
    logic [STATUS_W-1:0] status;
    word_t               entry_value;
    logic                last;
} deq_result_t;

class deque_checker #(int DEPTH = DEPTH_DEFAULT);
    localparam int HEAD_W = $clog2(DEPTH);

    word_t                  ring_word [DEPTH];
    bit [HEAD_W-1:0]        head_pos;
    bit [$clog2(DEPTH):0]   fill_count;
    deq_result_t            awaited_results [$];
    int                     mismatches;

    function new();
        head_pos   = '0;
        fill_count = '0;
        mismatches = 0;
        foreach (ring_word[k])
            ring_word[k] = '0;
    endfunction

    function void add_expected(logic [STATUS_W-1:0] st, word_t word, logic fin);
        deq_result_t r;
        r.status      = st;
        r.entry_value = word;
        r.last        = fin;
        awaited_results.push_back(r);
    endfunction

    function int awaited();
        return awaited_results.size();
    endfunction

    // update the shadow ring and queue up what the request must produce
    function void note_request(logic [REQ_W-1:0] kind, word_t word);
        int pos;
        case (kind)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (fill_count >= DEPTH)
                    add_expected(ST_FULL, '0, 1'b1);
                else
                begin
                    if (kind == REQ_PUSH_FRONT)
                    begin
                        head_pos = (head_pos == '0) ? HEAD_W'(DEPTH - 1)
                                                    : head_pos - 1'b1;
                        pos      = int'(head_pos);
                    end
                    else
                        pos = (int'(head_pos) + int'(fill_count)) % DEPTH;
                    ring_word[pos] = word;
                    fill_count++;
                    add_expected(ST_DONE, '0, 1'b1);
                end
            end
            REQ_LIST:
            begin
                if (fill_count == 0)
                    add_expected(ST_EMPTY, '0, 1'b1);
                else
                begin
                    pos = int'(head_pos);
                    for (int i = 0; i < fill_count; i++)
                    begin
                        add_expected(ST_ENTRY, ring_word[pos], i == fill_count - 1);
                        pos = (pos + 1) % DEPTH;
                    end
                end
            end
            REQ_DROP_FRONT, REQ_DROP_BACK:
            begin
                if (fill_count == 0)
                    add_expected(ST_EMPTY, '0, 1'b1);
                else
                begin
                    if (kind == REQ_DROP_FRONT)
                        head_pos = HEAD_W'((int'(head_pos) + 1) % DEPTH);
                    fill_count--;
                    add_expected(ST_DONE, '0, 1'b1);
                end
            end
            default:
                add_expected(ST_DONE, '0, 1'b1);
        endcase
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [STATUS_W-1:0] st, word_t word, logic fin);
        deq_result_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result status %0d value %0d last %0d",
                                      st, word, fin));
            return;
        end
        want = awaited_results.pop_front();
        if (st !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", st, want.status));
        if (word !== want.entry_value)
            report_mismatch($sformatf("entry_value %0d, wanted %0d", word, want.entry_value));
        if (fin !== want.last)
            report_mismatch($sformatf("last %0d, wanted %0d", fin, want.last));
    endtask
endclass

module tb_top;

    localparam int QDEPTH        = DEPTH_DEFAULT;
    localparam int STALL_CYCLES  = 300;    // long receiver hold-off
    localparam int STUCK_LIMIT   = 4000;   // cycles with no item moving on either side
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 20;     // longer than a full listing

    // request codes the block must ignore
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam word_t WORD_MIN = word_t'(32'h8000_0000);
    localparam word_t WORD_MAX = word_t'(32'h7fff_ffff);

    logic clk = 1'b0;
    logic rst_n;

    bit rsp_hold_req  = 1'b0;   // sender asks the receiver for a long stall
    bit sender_steady = 1'b0;   // sender offers back to back while set
    int stuck_cycles  = 0;

    deque_checker #(QDEPTH) shadow;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue #(.DEPTH(QDEPTH)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one request and hold it until the block takes it
    // valid stays high across back-to-back items, it is only lowered for a gap
    task automatic send_req(input logic [REQ_W-1:0] kind, input word_t word);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.item_value <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        shadow.note_request(kind, word);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (shadow.awaited() != 0)
            @(posedge clk);
    endtask

    // result sink: random ready gaps, long steady stretches, one long hold-off
    initial
    begin
        int run;
        int gap;
        bit hold_done;
        hold_done    = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_req && !hold_done)
            begin
                // the block fills its output side and must stall requests
                rsp_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            run = ($urandom_range(7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 10);
            repeat (run) @(posedge clk);
        end
    end

    // every accepted result is compared against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            shadow.check_result(rsp_ch.status, rsp_ch.entry_value, rsp_ch.last);
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        bit               filling;
        bit               grow;
        int               roll;
        logic [REQ_W-1:0] kind;
        word_t            word;

        shadow = new();
        filling = 1'b1;

        // every input known from time zero, reset held low before the run starts
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_PUSH_FRONT;
        req_ch.item_value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: listing reports empty, both drops underflow
        send_req(REQ_LIST, '0);
        send_req(REQ_DROP_FRONT, '0);
        send_req(REQ_DROP_BACK, '0);

        // first push at the front wraps the head below ring slot zero
        send_req(REQ_PUSH_FRONT, WORD_MIN);
        send_req(REQ_PUSH_BACK, WORD_MAX);
        send_req(REQ_PUSH_FRONT, -1);
        send_req(REQ_PUSH_BACK, '0);
        send_req(REQ_PUSH_BACK, word_t'($urandom));
        send_req(REQ_LIST, word_t'($urandom));

        // unused request codes change nothing and answer done
        for (int c = REQ_SPARE_LO; c <= REQ_SPARE_HI; c++)
            send_req(REQ_W'(c), word_t'($urandom));

        // drop from both ends down to empty, then two underflows past it
        send_req(REQ_DROP_FRONT, WORD_MAX);
        send_req(REQ_DROP_BACK, WORD_MIN);
        send_req(REQ_LIST, '0);
        send_req(REQ_DROP_FRONT, '0);
        send_req(REQ_DROP_BACK, '0);
        send_req(REQ_DROP_FRONT, '0);
        send_req(REQ_DROP_BACK, '0);
        send_req(REQ_DROP_BACK, '0);
        send_req(REQ_LIST, '0);

        // random part: alternate fill and drain phases so the ring runs full
        // and empty many times, with pushes to a full ring along the way
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 150)
                rsp_hold_req = 1'b1;
            if (i == 320)
                wait_drained();
            sender_steady = (i >= 420 && i < 470);

            if (shadow.fill_count == QDEPTH && $urandom_range(3) == 0)
                filling = 1'b0;
            if (shadow.fill_count == 0 && $urandom_range(2) == 0)
                filling = 1'b1;

            roll = $urandom_range(99);
            if (roll < 3)
                kind = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
            else if (roll < 15)
                kind = REQ_LIST;
            else
            begin
                grow = (roll < 75) ? filling : !filling;
                if (grow)
                    kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
                else
                    kind = $urandom_range(1) ? REQ_DROP_BACK : REQ_DROP_FRONT;
            end

            // words near the edges of the signed range now and then
            case ($urandom_range(11))
                0:       word = WORD_MIN;
                1:       word = WORD_MAX;
                2:       word = '0;
                3:       word = -1;
                default: word = word_t'($urandom);
            endcase

            send_req(kind, word);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (shadow.mismatches == 0 && shadow.awaited() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/deq_pkg.sv
rtl/deq_req_if.sv
rtl/deq_rsp_if.sv
rtl/deq_cell.sv
rtl/double_ended_queue.sv
dv/tb_top.sv
